### rtl/core/ddo_pkg.sv
// Shared constants, types and helper functions for the odometry datapath.
package ddo_pkg;

    localparam int DIVW     = 60;
    localparam int REMW     = 35;
    localparam int ATAN_IW  = 5;

    localparam logic [26:0]        DEG_Q32      = 27'd74961321;
    localparam logic signed [36:0] PI_Q32       = 37'sd13493037705;
    localparam logic signed [36:0] TWO_PI_Q32   = 37'sd26986075409;
    localparam logic signed [36:0] HALF_PI_Q32  = 37'sd6746518852;
    localparam longint             GAIN_INF_Q30 = 64'sd652032874;

    // Reciprocal of 2*pi scaled by 2^34 (2^66 over the Q32 constant), and 2*pi split for two narrow products.
    localparam logic [66:0] POW2_66   = 67'd1 << 66;
    localparam logic [31:0] MOD_RECIP = 32'(POW2_66 / 67'(TWO_PI_Q32));
    localparam logic [17:0] TWO_PI_HI = 18'(TWO_PI_Q32 >>> 17);
    localparam logic [16:0] TWO_PI_LO = TWO_PI_Q32[16:0];

    localparam logic [1:0] REG_WHEEL_RADIUS = 2'd0;
    localparam logic [1:0] REG_AXLE_LENGTH  = 2'd1;

    typedef struct packed {
        logic               clip;
        logic signed [31:0] val;
    } sat_t;

    function automatic logic signed [31:0] atan_q30(input logic [ATAN_IW-1:0] idx);
        case (idx)
            5'd0:    return 32'sd843314857;
            5'd1:    return 32'sd497837829;
            5'd2:    return 32'sd263043837;
            5'd3:    return 32'sd133525159;
            5'd4:    return 32'sd67021687;
            5'd5:    return 32'sd33543516;
            5'd6:    return 32'sd16775851;
            5'd7:    return 32'sd8388437;
            5'd8:    return 32'sd4194283;
            5'd9:    return 32'sd2097149;
            5'd10:   return 32'sd1048576;
            5'd11:   return 32'sd524288;
            5'd12:   return 32'sd262144;
            5'd13:   return 32'sd131072;
            5'd14:   return 32'sd65536;
            5'd15:   return 32'sd32768;
            5'd16:   return 32'sd16384;
            5'd17:   return 32'sd8192;
            5'd18:   return 32'sd4096;
            5'd19:   return 32'sd2048;
            5'd20:   return 32'sd1024;
            5'd21:   return 32'sd512;
            5'd22:   return 32'sd256;
            5'd23:   return 32'sd128;
            default: return 32'sd0;
        endcase
    endfunction

    // Round to nearest, ties away from zero, then shift right by s.
    function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                   input int unsigned s);
        logic [63:0] m;
        logic [63:0] q;
        m = v[63] ? 64'(-v) : 64'(v);
        q = (m + (64'd1 << (s - 1))) >> s;
        return v[63] ? $signed(-q) : $signed(q);
    endfunction

    function automatic sat_t sat32(input logic signed [63:0] v);
        sat_t r;
        if (v > 64'sd2147483647)
        begin
            r.clip = 1'b1;
            r.val  = 32'sh7fffffff;
        end
        else if (v < -64'sd2147483648)
        begin
            r.clip = 1'b1;
            r.val  = 32'sh80000000;
        end
        else
        begin
            r.clip = 1'b0;
            r.val  = v[31:0];
        end
        return r;
    endfunction

endpackage

### rtl/core/diff_drive_odometry.sv
// Differential-drive odometry: one shared multiplier, divider and CORDIC sequencer.
//
//  channel   dir  fields (low bit first)                               handshake
//  s_axis    in   right_delta[15:0], left_delta[15:0]                  tvalid/tready
//  m_axis    out  x_out[31:0], y_out[31:0], heading_out[31:0], sat     tvalid/tready
//  cfg       in   index 0 wheel_radius, index 1 axle_length            cfg_we
//
// The 60-step restoring division for the heading change dominates an update from
// request to result. The angle reduction uses a reciprocal product and one
// corrective subtract.
// tready is high only while the sequencer is idle; a finished pose waits in the
// output register and the next request is taken meanwhile. A second pose holds
// the sequencer in its last state until the first one is taken.
// Reset clears the pose and the sequencer and loads the register defaults.
module diff_drive_odometry
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // right_delta[15:0], left_delta[31:16]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // x_out, y_out, heading_out, saturated[96]
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [17:0]  cfg_data
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_MR1  = 5'd1;
    localparam logic [4:0] S_MR2  = 5'd2;
    localparam logic [4:0] S_AR   = 5'd3;
    localparam logic [4:0] S_ML1  = 5'd4;
    localparam logic [4:0] S_ML2  = 5'd5;
    localparam logic [4:0] S_AL   = 5'd6;
    localparam logic [4:0] S_P1   = 5'd7;
    localparam logic [4:0] S_P2   = 5'd8;
    localparam logic [4:0] S_DIV  = 5'd9;
    localparam logic [4:0] S_DTH  = 5'd10;
    localparam logic [4:0] S_MID  = 5'd11;
    localparam logic [4:0] S_MOD  = 5'd12;
    localparam logic [4:0] S_REM  = 5'd13;
    localparam logic [4:0] S_F1   = 5'd14;
    localparam logic [4:0] S_F2   = 5'd15;
    localparam logic [4:0] S_ZI   = 5'd16;
    localparam logic [4:0] S_CORD = 5'd17;
    localparam logic [4:0] S_CS   = 5'd18;
    localparam logic [4:0] S_MX   = 5'd19;
    localparam logic [4:0] S_MY   = 5'd20;
    localparam logic [4:0] S_DY   = 5'd21;
    localparam logic [4:0] S_DONE = 5'd22;
    localparam logic [4:0] S_RM1  = 5'd23;
    localparam logic [4:0] S_RM2  = 5'd24;
    localparam logic [4:0] S_RM3  = 5'd25;
    localparam logic [4:0] S_RC   = 5'd26;

    localparam longint GAIN_DEN = 3 * (64'sd1 <<< (2 * CORDIC_STEPS));
    localparam longint X0_L     = GAIN_INF_Q30 + (2 * GAIN_INF_Q30 + GAIN_DEN / 2) / GAIN_DEN;
    localparam logic signed [33:0]  X0       = 34'(X0_L);
    localparam logic [ATAN_IW-1:0]  LAST_IT  = ATAN_IW'(CORDIC_STEPS - 1);
    localparam logic [5:0]          LAST_DIV = 6'(DIVW - 1);

    logic [4:0]                state_reg;
    logic [15:0]               radius_reg;
    logic [17:0]               axle_reg;
    logic signed [15:0]        rt_reg;
    logic signed [15:0]        lt_reg;
    logic signed [65:0]        prod_reg;
    logic signed [43:0]        arc_r_reg;
    logic signed [43:0]        arc_l_reg;
    logic signed [44:0]        diff_reg;
    logic signed [44:0]        sum_reg;
    logic signed [31:0]        adv_reg;
    logic [DIVW-1:0]           div_q_reg;
    logic [REMW-1:0]           div_rem_reg;
    logic [REMW-1:0]           div_den_reg;
    logic                      div_neg_reg;
    logic [5:0]                div_cnt_reg;
    logic [22:0]               mod_q_reg;
    logic [57:0]               mod_r_reg;
    logic signed [60:0]        dth_reg;
    logic signed [60:0]        mid_reg;
    logic signed [36:0]        ang_reg;
    logic                      fold_neg_reg;
    logic signed [33:0]        cx_reg;
    logic signed [33:0]        cy_reg;
    logic signed [33:0]        cz_reg;
    logic [ATAN_IW-1:0]        it_reg;
    logic signed [32:0]        cos_reg;
    logic signed [32:0]        sin_reg;
    logic signed [31:0]        new_x_reg;
    logic signed [31:0]        new_y_reg;
    logic signed [31:0]        new_h_reg;
    logic                      new_clip_reg;
    logic signed [31:0]        pos_x_reg;
    logic signed [31:0]        pos_y_reg;
    logic signed [31:0]        heading_reg;
    logic                      sat_reg;
    logic                      out_valid_reg;

    logic signed [32:0]        mul_a;
    logic signed [32:0]        mul_b;
    logic signed [63:0]        arc_rnd;
    logic signed [63:0]        adv_rnd;
    logic signed [63:0]        half_dth;
    logic signed [63:0]        z_rnd;
    logic signed [63:0]        d_rnd;
    logic signed [63:0]        h_rnd;
    logic [43:0]               diff_abs;
    logic [60:0]               mid_abs;
    logic [17:0]               axle_eff;
    logic [REMW:0]             trial;
    logic                      ge;
    logic signed [33:0]        x_sh;
    logic signed [33:0]        y_sh;
    logic signed [33:0]        atan_v;
    logic signed [33:0]        cx_neg;
    logic signed [33:0]        cy_neg;
    sat_t                      sat_x;
    sat_t                      sat_y;
    sat_t                      sat_h;
    logic                      out_free;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, sat_reg, heading_reg, pos_y_reg, pos_x_reg};
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign axle_eff      = (axle_reg == 18'd0) ? 18'd1 : axle_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MR1:
            begin
                mul_a = 33'(rt_reg);
                mul_b = $signed({17'd0, radius_reg});
            end
            S_ML1:
            begin
                mul_a = 33'(lt_reg);
                mul_b = $signed({17'd0, radius_reg});
            end
            S_MR2, S_ML2:
            begin
                mul_a = prod_reg[32:0];
                mul_b = $signed({6'd0, DEG_Q32});
            end
            S_MOD:
            begin
                mul_a = $signed({1'b0, mid_abs[57:26]});
                mul_b = $signed({1'b0, MOD_RECIP});
            end
            S_RM1:
            begin
                mul_a = $signed({10'd0, prod_reg[62:40]});
                mul_b = $signed({15'd0, TWO_PI_HI});
            end
            S_RM2:
            begin
                mul_a = $signed({10'd0, mod_q_reg});
                mul_b = $signed({16'd0, TWO_PI_LO});
            end
            S_MX:
            begin
                mul_a = 33'(adv_reg);
                mul_b = cos_reg;
            end
            S_MY:
            begin
                mul_a = 33'(adv_reg);
                mul_b = sin_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        arc_rnd  = rnd_shr(64'(prod_reg), 16);
        adv_rnd  = rnd_shr(64'(sum_reg), 13);
        half_dth = rnd_shr(64'(dth_reg), 1);
        z_rnd    = rnd_shr(64'(ang_reg), 2);
        d_rnd    = rnd_shr(prod_reg[63:0], 34);
        h_rnd    = rnd_shr(64'(dth_reg), 16);
        diff_abs = diff_reg[44] ? 44'(-diff_reg) : 44'(diff_reg);
        mid_abs  = mid_reg[60] ? 61'(-mid_reg) : 61'(mid_reg);
        trial    = {div_rem_reg, div_q_reg[DIVW-1]};
        ge       = (trial >= {1'b0, div_den_reg});
        x_sh     = cx_reg >>> it_reg;
        y_sh     = cy_reg >>> it_reg;
        atan_v   = 34'(atan_q30(it_reg));
        cx_neg   = -cx_reg;
        cy_neg   = -cy_reg;
        sat_x    = sat32(64'(pos_x_reg) + d_rnd);
        sat_y    = sat32(64'(pos_y_reg) + d_rnd);
        sat_h    = sat32(64'(heading_reg) + h_rnd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 16'd6656;
            axle_reg   <= 18'd29184;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == REG_WHEEL_RADIUS)
            begin
                radius_reg <= cfg_data[15:0];
            end
            else if (cfg_addr == REG_AXLE_LENGTH)
            begin
                axle_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            heading_reg   <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        state_reg <= S_MR1;
                    end
                end
                S_MR1:  state_reg <= S_MR2;
                S_MR2:  state_reg <= S_AR;
                S_AR:   state_reg <= S_ML1;
                S_ML1:  state_reg <= S_ML2;
                S_ML2:  state_reg <= S_AL;
                S_AL:   state_reg <= S_P1;
                S_P1:   state_reg <= S_P2;
                S_P2:   state_reg <= S_DIV;
                S_DIV:
                begin
                    if (div_cnt_reg == LAST_DIV)
                    begin
                        state_reg <= S_DTH;
                    end
                end
                S_DTH:  state_reg <= S_MID;
                S_MID:  state_reg <= S_MOD;
                S_MOD:  state_reg <= S_RM1;
                S_RM1:  state_reg <= S_RM2;
                S_RM2:  state_reg <= S_RM3;
                S_RM3:  state_reg <= S_RC;
                S_RC:   state_reg <= S_REM;
                S_REM:  state_reg <= S_F1;
                S_F1:   state_reg <= S_F2;
                S_F2:   state_reg <= S_ZI;
                S_ZI:   state_reg <= S_CORD;
                S_CORD:
                begin
                    if (it_reg == LAST_IT)
                    begin
                        state_reg <= S_CS;
                    end
                end
                S_CS:   state_reg <= S_MX;
                S_MX:   state_reg <= S_MY;
                S_MY:   state_reg <= S_DY;
                S_DY:   state_reg <= S_DONE;
                S_DONE:
                begin
                    if (out_free)
                    begin
                        pos_x_reg     <= new_x_reg;
                        pos_y_reg     <= new_y_reg;
                        heading_reg   <= new_h_reg;
                        sat_reg       <= new_clip_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        unique case (state_reg)
            S_IDLE:
            begin
                rt_reg <= s_axis_tdata[15:0];
                lt_reg <= s_axis_tdata[31:16];
            end
            S_AR: arc_r_reg <= arc_rnd[43:0];
            S_AL: arc_l_reg <= arc_rnd[43:0];
            S_P1:
            begin
                diff_reg <= 45'(arc_r_reg) - 45'(arc_l_reg);
                sum_reg  <= 45'(arc_r_reg) + 45'(arc_l_reg);
            end
            S_P2:
            begin
                adv_reg     <= adv_rnd[31:0];
                div_q_reg   <= {diff_abs, 16'd0} + DIVW'(axle_eff >> 1);
                div_rem_reg <= '0;
                div_den_reg <= REMW'(axle_eff);
                div_neg_reg <= diff_reg[44];
                div_cnt_reg <= '0;
            end
            S_DIV:
            begin
                div_rem_reg <= ge ? REMW'(trial - {1'b0, div_den_reg}) : trial[REMW-1:0];
                div_q_reg   <= {div_q_reg[DIVW-2:0], ge};
                div_cnt_reg <= div_cnt_reg + 6'd1;
            end
            S_DTH:
            begin
                dth_reg <= div_neg_reg ? -$signed({1'b0, div_q_reg})
                                       : $signed({1'b0, div_q_reg});
            end
            S_MID:
            begin
                mid_reg <= $signed({{13{heading_reg[31]}}, heading_reg, 16'd0})
                         + half_dth[60:0];
            end
            S_MOD:
            begin
                mod_r_reg   <= mid_abs[57:0];
                div_neg_reg <= mid_reg[60];
            end
            S_RM1:
            begin
                mod_q_reg <= prod_reg[62:40];
            end
            S_RM2:
            begin
                mod_r_reg <= mod_r_reg - {prod_reg[40:0], 17'd0};
            end
            S_RM3:
            begin
                mod_r_reg <= mod_r_reg - 58'(prod_reg[39:0]);
            end
            S_RC:
            begin
                if (mod_r_reg >= 58'(TWO_PI_Q32))
                begin
                    mod_r_reg <= mod_r_reg - 58'(TWO_PI_Q32);
                end
            end
            S_REM:
            begin
                ang_reg <= div_neg_reg ? -$signed({2'b00, mod_r_reg[34:0]})
                                       : $signed({2'b00, mod_r_reg[34:0]});
            end
            S_F1:
            begin
                priority if (ang_reg > PI_Q32)
                begin
                    ang_reg <= ang_reg - TWO_PI_Q32;
                end
                else if (ang_reg < -PI_Q32)
                begin
                    ang_reg <= ang_reg + TWO_PI_Q32;
                end
            end
            S_F2:
            begin
                priority if (ang_reg > HALF_PI_Q32)
                begin
                    ang_reg      <= ang_reg - PI_Q32;
                    fold_neg_reg <= 1'b1;
                end
                else if (ang_reg < -HALF_PI_Q32)
                begin
                    ang_reg      <= ang_reg + PI_Q32;
                    fold_neg_reg <= 1'b1;
                end
                else
                begin
                    fold_neg_reg <= 1'b0;
                end
            end
            S_ZI:
            begin
                cz_reg <= z_rnd[33:0];
                cx_reg <= X0;
                cy_reg <= '0;
                it_reg <= '0;
            end
            S_CORD:
            begin
                if (!cz_reg[33])
                begin
                    cx_reg <= cx_reg - y_sh;
                    cy_reg <= cy_reg + x_sh;
                    cz_reg <= cz_reg - atan_v;
                end
                else
                begin
                    cx_reg <= cx_reg + y_sh;
                    cy_reg <= cy_reg - x_sh;
                    cz_reg <= cz_reg + atan_v;
                end
                it_reg <= it_reg + 1'b1;
            end
            S_CS:
            begin
                cos_reg <= fold_neg_reg ? cx_neg[32:0] : cx_reg[32:0];
                sin_reg <= fold_neg_reg ? cy_neg[32:0] : cy_reg[32:0];
            end
            S_MY:
            begin
                new_x_reg    <= sat_x.val;
                new_clip_reg <= sat_x.clip;
            end
            S_DY:
            begin
                new_y_reg    <= sat_y.val;
                new_h_reg    <= sat_h.val;
                new_clip_reg <= new_clip_reg | sat_y.clip | sat_h.clip;
            end
            default:
            begin
            end
        endcase
    end

endmodule

### rtl/core/ddo_checker.sv
// Port-level checks for the odometry block, bound to the top level.
module ddo_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata
);

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("tready high right after a request");

    a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result shown while sequencer busy");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("tvalid dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("tdata changed while stalled");

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
